// File: hw/rtl/cmlut_pkg.sv
// ----------------------------------------------------------------------------
// cmlut_pkg
// Shared types, constants and color tables of the colormap lookup block.
// ----------------------------------------------------------------------------
package cmlut_pkg;

   localparam int TABLE_ENTRIES = 32;
   localparam int NUM_MAPS      = 13;
   localparam int FRACTION_BITS = 8;

   localparam int SAMPLE_W = 16;
   localparam int SCALE_W  = 32;
   localparam int POS_W    = SAMPLE_W + SCALE_W;
   localparam int POS_FRAC = 16;
   localparam int ENTRY_W  = $clog2(TABLE_ENTRIES);
   localparam int MAP_W    = 4;
   localparam int COLOR_W  = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_VALUE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_VALUE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_SCALE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_SELECT  = 2'd3;

   localparam logic signed [SAMPLE_W-1:0] MIN_VALUE_RESET   = 16'sd0;
   localparam logic signed [SAMPLE_W-1:0] MAX_VALUE_RESET   = 16'sd32767;
   localparam logic [SCALE_W-1:0]         RANGE_SCALE_RESET = 32'd64;
   localparam logic [MAP_W-1:0]           MAP_SELECT_RESET  = 4'd0;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } rgb_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] min_value;
      logic signed [SAMPLE_W-1:0] max_value;
      logic [SCALE_W-1:0]         range_scale;
      logic [MAP_W-1:0]           map_index;
   } cfg_type;

   typedef struct packed {
      rgb_type                  c0;
      rgb_type                  c1;
      logic [FRACTION_BITS-1:0] frac;
   } blend_type;

   localparam rgb_type CMAP [NUM_MAPS][TABLE_ENTRIES] = '{
      '{'{68,1,84},'{70,12,95},'{71,24,106},'{72,34,115},'{70,45,124},'{68,55,129},
        '{65,65,134},'{61,74,137},'{57,84,139},'{53,92,140},'{49,100,141},'{46,108,142},
        '{42,117,142},'{39,124,142},'{36,132,141},'{34,139,141},'{31,148,139},'{30,155,137},
        '{31,163,134},'{36,170,130},'{46,178,124},'{57,185,118},'{71,192,110},'{87,198,101},
        '{107,205,89},'{126,210,78},'{146,215,65},'{167,219,51},'{191,223,36},'{212,225,26},
        '{233,228,25},'{253,231,36}},
      '{'{12,7,134},'{33,5,143},'{49,4,150},'{63,3,156},'{78,2,161},'{90,0,165},
        '{103,0,167},'{115,0,168},'{129,4,167},'{140,10,164},'{151,19,160},'{162,28,154},
        '{173,38,146},'{182,47,139},'{190,56,131},'{198,65,124},'{207,75,116},'{214,85,109},
        '{220,94,102},'{227,103,95},'{233,114,87},'{238,124,80},'{243,134,73},'{246,145,66},
        '{250,157,58},'{252,169,52},'{253,181,45},'{253,193,40},'{251,208,36},'{248,221,36},
        '{244,234,38},'{239,248,33}},
      '{'{0,34,77},'{0,40,91},'{0,45,105},'{4,50,112},'{28,56,110},'{40,62,109},
        '{50,68,108},'{59,73,107},'{69,79,107},'{77,85,108},'{84,90,108},'{91,96,110},
        '{99,102,111},'{106,108,113},'{113,114,115},'{120,120,118},'{128,126,120},
        '{135,132,120},'{143,138,119},'{151,144,118},'{160,151,117},'{168,158,115},
        '{176,164,112},'{184,171,109},'{194,178,105},'{202,185,100},'{211,192,95},
        '{219,199,89},'{229,207,80},'{238,215,71},'{248,222,59},'{253,231,55}},
      '{'{48,18,59},'{57,41,114},'{64,64,161},'{68,86,199},'{70,109,230},'{70,130,248},
        '{64,150,254},'{52,170,248},'{37,192,230},'{26,209,210},'{24,224,189},'{34,235,169},
        '{59,244,141},'{89,251,114},'{120,254,89},'{149,254,68},'{174,249,55},'{195,241,51},
        '{214,229,53},'{231,215,56},'{244,196,58},'{251,179,54},'{254,158,46},'{252,134,36},
        '{246,107,24},'{237,85,15},'{226,66,9},'{212,50,5},'{192,35,2},'{172,22,1},
        '{148,12,1},'{122,4,2}},
      '{'{255,247,243},'{254,241,237},'{253,235,231},'{253,229,226},'{252,223,219},
        '{252,216,212},'{252,209,205},'{252,202,198},'{251,194,191},'{251,184,188},
        '{250,175,185},'{250,165,182},'{249,153,178},'{248,139,173},'{248,125,168},
        '{247,111,163},'{243,96,159},'{236,83,157},'{230,70,154},'{223,57,152},
        '{212,42,146},'{200,30,140},'{189,17,134},'{177,4,127},'{162,1,124},'{149,1,122},
        '{136,1,121},'{123,1,119},'{109,0,115},'{97,0,112},'{85,0,109},'{73,0,106}},
      '{'{247,244,249},'{242,239,246},'{238,234,243},'{234,229,241},'{230,223,238},
        '{225,213,232},'{220,203,227},'{216,193,222},'{211,182,216},'{208,173,211},
        '{205,163,207},'{202,154,202},'{203,143,196},'{208,131,190},'{214,119,185},
        '{219,107,179},'{224,92,170},'{226,77,161},'{228,62,151},'{230,47,142},
        '{226,36,128},'{220,31,115},'{214,25,102},'{207,19,89},'{194,14,81},'{181,9,77},
        '{167,5,72},'{153,0,67},'{139,0,58},'{127,0,49},'{115,0,40},'{103,0,31}},
      '{'{247,252,240},'{241,249,234},'{235,247,229},'{229,245,224},'{223,242,218},
        '{218,240,212},'{213,238,207},'{208,236,201},'{201,234,195},'{192,230,191},
        '{183,226,187},'{174,223,183},'{163,219,182},'{151,214,186},'{140,210,190},
        '{129,206,193},'{116,200,198},'{105,194,201},'{94,187,205},'{82,181,209},
        '{71,172,207},'{63,162,202},'{54,152,196},'{45,142,191},'{35,132,186},
        '{26,123,181},'{18,114,177},'{9,105,172},'{8,94,161},'{8,84,150},'{8,74,139},
        '{8,64,129}},
      '{'{255,247,251},'{250,242,248},'{245,238,246},'{240,234,244},'{235,230,241},
        '{227,224,238},'{220,219,235},'{213,213,232},'{205,207,229},'{194,202,226},
        '{183,197,223},'{173,192,220},'{160,186,217},'{148,181,214},'{135,176,211},
        '{123,171,208},'{107,165,204},'{91,159,201},'{76,152,197},'{60,146,193},
        '{45,138,189},'{33,130,185},'{20,122,181},'{8,114,177},'{4,107,168},'{4,101,159},
        '{4,96,151},'{4,90,142},'{3,81,127},'{3,73,114},'{2,64,101},'{2,56,88}},
      '{'{255,255,217},'{250,253,206},'{245,251,196},'{241,249,186},'{235,247,177},
        '{226,243,177},'{216,239,178},'{207,236,179},'{193,231,180},'{175,223,182},
        '{157,216,184},'{139,209,185},'{120,202,187},'{104,196,190},'{89,191,192},
        '{73,185,194},'{59,176,195},'{50,167,194},'{41,158,193},'{32,148,192},
        '{29,136,187},'{31,123,181},'{32,110,175},'{33,97,169},'{34,85,163},'{35,74,158},
        '{36,64,153},'{36,53,148},'{29,46,133},'{22,40,118},'{15,34,103},'{8,29,88}},
      '{'{0,0,0},'{8,8,8},'{16,16,16},'{24,24,24},'{32,32,32},'{40,40,40},'{48,48,48},
        '{56,56,56},'{65,65,65},'{73,73,73},'{81,81,81},'{89,89,89},'{99,99,99},
        '{107,107,107},'{115,115,115},'{123,123,123},'{131,131,131},'{140,140,140},
        '{147,147,147},'{156,156,156},'{165,165,165},'{173,173,173},'{181,181,181},
        '{189,189,189},'{198,198,198},'{206,206,206},'{214,214,214},'{222,222,222},
        '{231,231,231},'{239,239,239},'{247,247,247},'{255,255,255}},
      '{'{10,0,0},'{31,0,0},'{52,0,0},'{73,0,0},'{97,0,0},'{118,0,0},'{139,0,0},
        '{160,0,0},'{183,0,0},'{204,0,0},'{225,0,0},'{246,0,0},'{255,15,0},'{255,36,0},
        '{255,57,0},'{255,78,0},'{255,102,0},'{255,123,0},'{255,144,0},'{255,165,0},
        '{255,188,0},'{255,209,0},'{255,230,0},'{255,251,0},'{255,255,30},'{255,255,62},
        '{255,255,93},'{255,255,125},'{255,255,160},'{255,255,191},'{255,255,223},
        '{255,255,255}},
      '{'{0,0,0},'{12,0,0},'{24,0,0},'{36,0,0},'{49,0,0},'{61,0,0},'{73,0,0},'{85,0,0},
        '{98,0,0},'{110,0,0},'{122,0,0},'{134,0,0},'{148,0,0},'{160,0,0},'{172,0,0},
        '{184,0,0},'{197,8,0},'{210,25,0},'{221,40,0},'{234,57,0},'{247,75,0},
        '{255,91,0},'{255,107,0},'{255,123,0},'{255,141,27},'{255,157,59},'{255,173,91},
        '{255,189,123},'{255,207,159},'{255,223,191},'{255,239,223},'{255,255,255}},
      '{'{0,0,0},'{9,6,3},'{19,12,7},'{29,18,11},'{40,25,16},'{50,32,20},'{60,38,24},
        '{70,44,28},'{81,51,32},'{91,57,36},'{101,64,40},'{111,70,44},'{122,77,49},
        '{132,83,53},'{142,89,57},'{151,96,61},'{163,103,65},'{172,109,69},'{182,115,73},
        '{192,121,77},'{203,128,82},'{213,135,86},'{223,141,90},'{233,147,94},
        '{244,154,98},'{254,160,102},'{255,167,106},'{255,173,110},'{255,180,114},
        '{255,186,118},'{255,192,122},'{255,199,126}}
   };

endpackage

// File: hw/rtl/cmlut_clamp.sv
// ----------------------------------------------------------------------------
// cmlut_clamp
// Stage 1: clamps the sample to the configured range and removes the offset.
// ----------------------------------------------------------------------------
module cmlut_clamp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  cmlut_pkg::cfg_type                     cfg,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  logic signed [cmlut_pkg::SAMPLE_W-1:0]  sample,
   output logic                                   out_valid,
   input  logic                                   out_ready,
   output logic [cmlut_pkg::SAMPLE_W-1:0]         offset
);

   logic signed [cmlut_pkg::SAMPLE_W-1:0] upper_clamped;
   logic signed [cmlut_pkg::SAMPLE_W-1:0] lower_clamped;
   logic [cmlut_pkg::SAMPLE_W:0]          diff;
   logic                                  valid_ff;
   logic [cmlut_pkg::SAMPLE_W-1:0]        offset_ff;
   logic [cmlut_pkg::SAMPLE_W-1:0]        offset_in;

   always_comb begin
      upper_clamped = (sample > cfg.max_value) ? cfg.max_value : sample;
      lower_clamped = (upper_clamped < cfg.min_value) ? cfg.min_value : upper_clamped;
      diff = {lower_clamped[cmlut_pkg::SAMPLE_W-1], lower_clamped}
           - {cfg.min_value[cmlut_pkg::SAMPLE_W-1], cfg.min_value};
      offset_in = diff[cmlut_pkg::SAMPLE_W-1:0];
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         offset_ff <= offset_in;
      end
   end

   assign out_valid = valid_ff;
   assign offset    = offset_ff;

endmodule

// File: hw/rtl/cmlut_scale.sv
// ----------------------------------------------------------------------------
// cmlut_scale
// Stage 2: multiplies the offset sample by the range scale into a 32.16 position.
// ----------------------------------------------------------------------------
module cmlut_scale (
   input  logic                             clock,
   input  logic                             reset,
   input  cmlut_pkg::cfg_type               cfg,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic [cmlut_pkg::SAMPLE_W-1:0]   offset,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic [cmlut_pkg::POS_W-1:0]      position
);

   logic                           valid_ff;
   logic [cmlut_pkg::POS_W-1:0]    position_ff;
   logic [cmlut_pkg::POS_W-1:0]    position_in;

   assign position_in = cmlut_pkg::POS_W'(offset) * cmlut_pkg::POS_W'(cfg.range_scale);
   assign in_ready    = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         position_ff <= position_in;
      end
   end

   assign out_valid = valid_ff;
   assign position  = position_ff;

endmodule

// File: hw/rtl/cmlut_lookup.sv
// ----------------------------------------------------------------------------
// cmlut_lookup
// Stage 3: splits the position, saturates at the last entry and reads the
// two neighboring colors from the table.
// ----------------------------------------------------------------------------
module cmlut_lookup (
   input  logic                          clock,
   input  logic                          reset,
   input  cmlut_pkg::cfg_type            cfg,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [cmlut_pkg::POS_W-1:0]   position,
   output logic                          out_valid,
   input  logic                          out_ready,
   output cmlut_pkg::blend_type          blend
);

   localparam logic [cmlut_pkg::ENTRY_W-1:0] LAST_ENTRY =
      cmlut_pkg::ENTRY_W'(cmlut_pkg::TABLE_ENTRIES - 1);
   localparam int INT_W = cmlut_pkg::POS_W - cmlut_pkg::POS_FRAC;

   logic [INT_W-1:0]                     entry_int;
   logic                                 saturate;
   logic [cmlut_pkg::ENTRY_W-1:0]        index0;
   logic [cmlut_pkg::ENTRY_W-1:0]        index1;
   logic                                 valid_ff;
   cmlut_pkg::blend_type                 blend_ff;
   cmlut_pkg::blend_type                 blend_in;

   always_comb begin
      entry_int = position[cmlut_pkg::POS_W-1:cmlut_pkg::POS_FRAC];
      saturate  = entry_int >= INT_W'(cmlut_pkg::TABLE_ENTRIES - 1);
      index0    = saturate ? LAST_ENTRY : entry_int[cmlut_pkg::ENTRY_W-1:0];
      index1    = saturate ? LAST_ENTRY : index0 + cmlut_pkg::ENTRY_W'(1);
      blend_in.c0   = cmlut_pkg::CMAP[cfg.map_index][index0];
      blend_in.c1   = cmlut_pkg::CMAP[cfg.map_index][index1];
      blend_in.frac = saturate ? '0
         : position[cmlut_pkg::POS_FRAC-1 -: cmlut_pkg::FRACTION_BITS];
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         blend_ff <= blend_in;
      end
   end

   assign out_valid = valid_ff;
   assign blend     = blend_ff;

endmodule

// File: hw/rtl/cmlut_blend.sv
// ----------------------------------------------------------------------------
// cmlut_blend
// Stage 4: linear blend of the two neighboring colors, truncated, into the
// output register.
// ----------------------------------------------------------------------------
module cmlut_blend (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  cmlut_pkg::blend_type            blend,
   output logic                            out_valid,
   input  logic                            out_ready,
   output cmlut_pkg::rgb_type              color
);

   localparam int FB  = cmlut_pkg::FRACTION_BITS;
   localparam int CW  = cmlut_pkg::COLOR_W;
   localparam int SUM_W = CW + FB + 1;

   function automatic logic [CW-1:0] mix(input logic [CW-1:0] c0,
                                         input logic [CW-1:0] c1,
                                         input logic [FB-1:0] frac);
      logic [FB:0]      w0;
      logic [SUM_W-1:0] sum;
      w0  = ((FB+1)'(1) << FB) - {1'b0, frac};
      sum = SUM_W'(c0) * SUM_W'(w0) + SUM_W'(c1) * SUM_W'(frac);
      return sum[FB +: CW];
   endfunction

   logic                  valid_ff;
   cmlut_pkg::rgb_type    color_ff;
   cmlut_pkg::rgb_type    color_in;

   always_comb begin
      color_in.red   = mix(blend.c0.red,   blend.c1.red,   blend.frac);
      color_in.green = mix(blend.c0.green, blend.c1.green, blend.frac);
      color_in.blue  = mix(blend.c0.blue,  blend.c1.blue,  blend.frac);
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         color_ff <= color_in;
      end
   end

   assign out_valid = valid_ff;
   assign color     = color_ff;

endmodule

// File: hw/rtl/colormap_lookup_interpolate_top.sv
// ----------------------------------------------------------------------------
// colormap_lookup_interpolate_top
// False-color mapping of signed samples through a stored 32-entry RGB table
// with linear interpolation between neighboring entries.
//
// req_ channel: one signed 16-bit sample per transaction, taken when
//   req_valid is high and req_stall is low.
// rsp_ channel: one red/green/blue result per sample, in order, taken when
//   rsp_valid is high and rsp_stall is low.
// csr_ channel: register writes (min_value, max_value, range_scale,
//   map_select by index 0..3); csr_ready is always high. Write only while
//   no transaction is in flight.
// Pipeline: clamp, multiply, table read, blend; four register stages, each
//   registering its result. One sample per cycle is sustained while the
//   output is not stalled; the 16x32 multiply and the table read each own a
//   stage.
// Stall: each stage holds its item while the next one is full and stalled;
//   empty stages keep filling, so up to four samples are taken while the
//   output is stalled. Results are held stable until taken.
// Reset: clears all stage valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module colormap_lookup_interpolate_top (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [cmlut_pkg::SAMPLE_W-1:0]   req_sample,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [cmlut_pkg::COLOR_W-1:0]           rsp_red,
   output logic [cmlut_pkg::COLOR_W-1:0]           rsp_green,
   output logic [cmlut_pkg::COLOR_W-1:0]           rsp_blue,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [cmlut_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [cmlut_pkg::CSR_DATA_W-1:0]        csr_data
);

   logic signed [cmlut_pkg::SAMPLE_W-1:0] min_value_ff;
   logic signed [cmlut_pkg::SAMPLE_W-1:0] max_value_ff;
   logic [cmlut_pkg::SCALE_W-1:0]         range_scale_ff;
   logic [cmlut_pkg::MAP_W-1:0]           map_select_ff;
   cmlut_pkg::cfg_type                    cfg;

   logic                                  s1_valid;
   logic                                  s1_ready;
   logic [cmlut_pkg::SAMPLE_W-1:0]        s1_offset;
   logic                                  s2_valid;
   logic                                  s2_ready;
   logic [cmlut_pkg::POS_W-1:0]           s2_position;
   logic                                  s3_valid;
   logic                                  s3_ready;
   cmlut_pkg::blend_type                  s3_blend;
   logic                                  req_ready;
   cmlut_pkg::rgb_type                    color;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_value_ff   <= cmlut_pkg::MIN_VALUE_RESET;
         max_value_ff   <= cmlut_pkg::MAX_VALUE_RESET;
         range_scale_ff <= cmlut_pkg::RANGE_SCALE_RESET;
         map_select_ff  <= cmlut_pkg::MAP_SELECT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            cmlut_pkg::CSR_MIN_VALUE: begin
               min_value_ff <= csr_data[cmlut_pkg::SAMPLE_W-1:0];
            end
            cmlut_pkg::CSR_MAX_VALUE: begin
               max_value_ff <= csr_data[cmlut_pkg::SAMPLE_W-1:0];
            end
            cmlut_pkg::CSR_RANGE_SCALE: begin
               range_scale_ff <= csr_data[cmlut_pkg::SCALE_W-1:0];
            end
            cmlut_pkg::CSR_MAP_SELECT: begin
               map_select_ff <= csr_data[cmlut_pkg::MAP_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // maps past the last one use the last table
   always_comb begin
      cfg.min_value   = min_value_ff;
      cfg.max_value   = max_value_ff;
      cfg.range_scale = range_scale_ff;
      cfg.map_index   = (map_select_ff >= cmlut_pkg::MAP_W'(cmlut_pkg::NUM_MAPS))
                      ? cmlut_pkg::MAP_W'(cmlut_pkg::NUM_MAPS - 1) : map_select_ff;
   end

   cmlut_clamp u_clamp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .sample    (req_sample),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .offset    (s1_offset)
   );

   cmlut_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .offset    (s1_offset),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .position  (s2_position)
   );

   cmlut_lookup u_lookup (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .position  (s2_position),
      .out_valid (s3_valid),
      .out_ready (s3_ready),
      .blend     (s3_blend)
   );

   cmlut_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid),
      .in_ready  (s3_ready),
      .blend     (s3_blend),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .color     (color)
   );

   assign req_stall = !req_ready;
   assign rsp_red   = color.red;
   assign rsp_green = color.green;
   assign rsp_blue  = color.blue;

endmodule

// File: bench/tb_colormap_lookup_interpolate_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_colormap_lookup_interpolate_top
// Self-checking bench for the colormap lookup and interpolation block.
// Samples are fed from a queue by a clocked driver, and each accepted
// transaction is mapped to its expected color by an independent predictor
// that uses the stored color tables. A clocked monitor compares every
// returned color, channel by channel, with the oldest expected color.
// Directed items cover the clamp bounds, the table ends, an out-of-range map
// number, reversed bounds, a zero scale and a saturating scale. Random phases
// then reprogram the registers between drained batches, with random gaps
// on both sides and quiet stretches, after one long output hold-off.
// ----------------------------------------------------------------------------
module tb_colormap_lookup_interpolate_top;
   import cmlut_pkg::*;

   localparam int HOLD_CYCLES  = 80;
   localparam int DRAIN_CYCLES = 12;
   localparam int RANDOM_ITEMS = 300;

   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic                       req_valid  = 1'b0;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_sample = '0;
   logic                       rsp_valid;
   logic                       rsp_stall  = 1'b0;
   logic [COLOR_W-1:0]         rsp_red;
   logic [COLOR_W-1:0]         rsp_green;
   logic [COLOR_W-1:0]         rsp_blue;
   logic                       csr_valid  = 1'b0;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index  = '0;
   logic [CSR_DATA_W-1:0]      csr_data   = '0;

   // register copies used for prediction
   logic signed [SAMPLE_W-1:0] cur_min   = MIN_VALUE_RESET;
   logic signed [SAMPLE_W-1:0] cur_max   = MAX_VALUE_RESET;
   logic [SCALE_W-1:0]         cur_scale = RANGE_SCALE_RESET;
   logic [MAP_W-1:0]           cur_map   = MAP_SELECT_RESET;

   logic signed [SAMPLE_W-1:0] sample_queue [$];
   rgb_type                    expected_colors [$];
   int samples_offered = 0;
   int samples_taken   = 0;
   int send_gap        = 0;
   int stall_left      = 0;
   int hold_left       = 0;
   int hold_requests   = 0;
   int hold_served     = 0;
   int error_count     = 0;
   bit steady_flow     = 1'b0;

   colormap_lookup_interpolate_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_sample (req_sample),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_red    (rsp_red),
      .rsp_green  (rsp_green),
      .rsp_blue   (rsp_blue),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [COLOR_W-1:0] mix(logic [COLOR_W-1:0] c0, logic [COLOR_W-1:0] c1,
                                              logic [FRACTION_BITS:0] f);
      int acc;
      acc = int'(c0) * ((1 << FRACTION_BITS) - int'(f)) + int'(c1) * int'(f);
      return acc[COLOR_W+FRACTION_BITS-1:FRACTION_BITS];
   endfunction

   function automatic rgb_type color_of(logic signed [SAMPLE_W-1:0] sample);
      int               level;
      int               map_no;
      int               entry;
      logic [POS_W-1:0] position;
      logic [POS_W-1:0] scale_w;
      logic [FRACTION_BITS:0] f;
      rgb_type          c0;
      rgb_type          c1;
      rgb_type          mixed;
      level = int'(sample);
      if (level > int'(cur_max)) level = int'(cur_max);
      if (level < int'(cur_min)) level = int'(cur_min);
      map_no = (cur_map >= NUM_MAPS) ? NUM_MAPS - 1 : int'(cur_map);
      position = POS_W'(level - int'(cur_min));
      scale_w  = POS_W'(cur_scale);
      position = position * scale_w;
      if (position[POS_W-1:POS_FRAC] >= TABLE_ENTRIES - 1) begin
         return CMAP[map_no][TABLE_ENTRIES-1];
      end
      entry = int'(position[POS_FRAC+ENTRY_W-1:POS_FRAC]);
      f = {1'b0, position[POS_FRAC-1 -: FRACTION_BITS]};
      c0 = CMAP[map_no][entry];
      c1 = CMAP[map_no][entry+1];
      mixed.red   = mix(c0.red, c1.red, f);
      mixed.green = mix(c0.green, c1.green, f);
      mixed.blue  = mix(c0.blue, c1.blue, f);
      return mixed;
   endfunction

   function automatic int idle_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic check_channel(string name, logic [COLOR_W-1:0] want, logic [COLOR_W-1:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // sample driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && samples_taken != samples_offered) begin
         // hold the stalled transaction
      end else if (send_gap > 0) begin
         req_valid <= 1'b0;
         send_gap--;
      end else if (sample_queue.size() > 0) begin
         req_valid  <= 1'b1;
         req_sample <= sample_queue.pop_front();
         samples_offered++;
         if (!steady_flow) send_gap = idle_len();
      end else begin
         req_valid <= 1'b0;
      end
   end

   // result stall driver
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left   = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (steady_flow) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         stall_left = idle_len();
      end
   end

   // monitor
   always @(posedge clock) begin
      rgb_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            samples_taken++;
            expected_colors.push_back(color_of(req_sample));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_colors.size() == 0) begin
               error_count++;
               $display("%0t: unexpected transaction, expected none, actual %0d/%0d/%0d",
                        $time, rsp_red, rsp_green, rsp_blue);
            end else begin
               want = expected_colors.pop_front();
               check_channel("red", want.red, rsp_red);
               check_channel("green", want.green, rsp_green);
               check_channel("blue", want.blue, rsp_blue);
            end
         end
      end
   end

   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         CSR_MIN_VALUE:   cur_min   = value[SAMPLE_W-1:0];
         CSR_MAX_VALUE:   cur_max   = value[SAMPLE_W-1:0];
         CSR_RANGE_SCALE: cur_scale = value[SCALE_W-1:0];
         CSR_MAP_SELECT:  cur_map   = value[MAP_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(input int lo, input int hi, input logic [SCALE_W-1:0] scale,
                             input int map_no);
      write_register(CSR_MIN_VALUE, lo);
      write_register(CSR_MAX_VALUE, hi);
      write_register(CSR_RANGE_SCALE, scale);
      write_register(CSR_MAP_SELECT, map_no);
   endtask

   task automatic wait_idle();
      while (sample_queue.size() != 0 || samples_taken != samples_offered ||
             expected_colors.size() != 0) @(negedge clock);
   endtask

   task automatic send_all(input int values[$]);
      foreach (values[i]) sample_queue.push_back(SAMPLE_W'(values[i]));
      wait_idle();
   endtask

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      int lo;
      int hi;
      int choice;
      choice = $urandom_range(0, 9);
      lo = int'(cur_min);
      hi = int'(cur_max);
      if (lo > hi || choice == 7) return SAMPLE_W'($urandom);
      if (choice == 8) return SAMPLE_W'($urandom_range(0, 1) ? lo : hi);
      if (choice == 9) begin
         if ($urandom_range(0, 1)) return SAMPLE_W'((lo > -32768) ? lo - 1 : lo);
         return SAMPLE_W'((hi < 32767) ? hi + 1 : hi);
      end
      lo = (lo - 8 < -32768) ? -32768 : lo - 8;
      hi = (hi + 8 > 32767) ? 32767 : hi + 8;
      return SAMPLE_W'(lo + int'($urandom_range(0, hi - lo)));
   endfunction

   task automatic random_phase(input int count);
      int                 lo;
      int                 hi;
      int                 swap;
      int                 kind;
      logic [SCALE_W-1:0] scale;
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
         lo = $urandom_range(0, 65535 - 64) - 32768;
         hi = lo + $urandom_range(1, 64);
      end else begin
         lo = $urandom_range(0, 65535) - 32768;
         hi = $urandom_range(0, 65535) - 32768;
         if (kind < 9 && lo > hi) begin
            swap = lo;
            lo   = hi;
            hi   = swap;
         end
         if (kind < 9 && lo == hi) begin
            if (hi == 32767) lo--;
            else hi++;
         end
      end
      if (kind < 8) scale = 2097152 / (hi - lo);
      else scale = $urandom;
      set_config(lo, hi, scale, $urandom_range(0, 15));
      steady_flow = ($urandom_range(0, 3) == 0);
      repeat (count) sample_queue.push_back(pick_sample());
      wait_idle();
      steady_flow = 1'b0;
   endtask

   initial begin
      int directed [$];
      int random_sent;
      int count;
      random_sent = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // register defaults
      directed = '{-32768, -1, 0, 1, 1023, 1025, 21845, 32767};
      send_all(directed);
      // full range, last map
      set_config(-32768, 32767, 32, 12);
      directed = '{-32768, 0, 32767};
      send_all(directed);
      // narrow range, map number past the last table
      set_config(-100, 100, 10485, 15);
      directed = '{-100, 100, -101, 101, 7};
      send_all(directed);
      // reversed bounds
      set_config(1000, -1000, 32'h0001_2345, 9);
      directed = '{0, -32768, 32767};
      send_all(directed);
      // zero scale
      set_config(-32768, 32767, 0, 4);
      directed = '{-32768, 32767};
      send_all(directed);
      // saturating scale
      set_config(-32768, 32767, 32'hFFFF_FFFF, 10);
      directed = '{-32768, -32767, 0, 32767};
      send_all(directed);

      // long output hold-off while the sender keeps offering
      set_config(-32768, 32767, 32, 3);
      steady_flow = 1'b1;
      hold_requests++;
      repeat (60) sample_queue.push_back(SAMPLE_W'($urandom));
      wait_idle();
      steady_flow = 1'b0;

      while (random_sent < RANDOM_ITEMS) begin
         count = $urandom_range(30, 60);
         random_phase(count);
         random_sent += count;
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
